// ===== hdl/vfa_pkg.sv =====
// Shared types and constants of the fixed-point 3D vector unit.
package vfa_pkg;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_DOT   = 3'd2;
  localparam logic [2:0] CMD_CROSS = 3'd3;
  localparam logic [2:0] CMD_LEN   = 3'd4;
  localparam logic [2:0] CMD_NORM  = 3'd5;
  localparam logic [2:0] CMD_AREA  = 3'd6;

  localparam int SQ_CELLS  = 34;
  localparam int DIV_CELLS = 17;
  localparam int PRE_STAGES = 4;
  localparam int N_STAGES = PRE_STAGES + SQ_CELLS + DIV_CELLS;

  // Square root cell data: radicand shifted out two bits per cell.
  typedef struct packed {
    logic [67:0] rad;
    logic [35:0] rem;
    logic [33:0] root;
  } sq_t;

  // Divider cell data: one divisor shared by three lanes.
  typedef struct packed {
    logic [39:0]       dv;
    logic [2:0][39:0]  rem;
    logic [2:0][16:0]  q;
  } dv_t;

  // Item data that travels beside the arithmetic chains.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [2:0][15:0]  a;
    logic [2:0][39:0]  rv;
    logic [39:0]       sc;
    logic [33:0]       root;
  } side_t;

endpackage

// ===== hdl/vfa_sqrt_cell.sv =====
// One step of the restoring square root: one root bit per cell.
module vfa_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  vfa_pkg::sq_t d_in,
  output vfa_pkg::sq_t d_out
);

  vfa_pkg::sq_t cell_r;
  vfa_pkg::sq_t cell_nxt;
  logic [37:0]  rem_sh;
  logic [37:0]  trial;
  logic [37:0]  diff;
  logic         ge;

  always_comb begin
    rem_sh = {d_in.rem, d_in.rad[67:66]};
    trial  = {2'b00, d_in.root, 2'b01};
    ge     = (rem_sh >= trial);
    diff   = rem_sh - trial;
    cell_nxt.rad  = {d_in.rad[65:0], 2'b00};
    cell_nxt.rem  = ge ? diff[35:0] : rem_sh[35:0];
    cell_nxt.root = {d_in.root[32:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

// ===== hdl/vfa_div_cell.sv =====
// One step of the restoring divider: one quotient bit per cell, three lanes.
module vfa_div_cell (
  input  logic         clk,
  input  logic         en,
  input  vfa_pkg::dv_t d_in,
  output vfa_pkg::dv_t d_out
);

  vfa_pkg::dv_t cell_r;
  vfa_pkg::dv_t cell_nxt;

  always_comb begin
    cell_nxt.dv = {1'b0, d_in.dv[39:1]};
    for (int i = 0; i < 3; i++) begin
      if (d_in.rem[i] >= d_in.dv) begin
        cell_nxt.rem[i] = d_in.rem[i] - d_in.dv;
        cell_nxt.q[i]   = {d_in.q[i][15:0], 1'b1};
      end else begin
        cell_nxt.rem[i] = d_in.rem[i];
        cell_nxt.q[i]   = {d_in.q[i][15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

// ===== hdl/vector3_fixed_point_alu.sv =====
// Top level of the fixed-point 3D vector unit: product stages, root and divider chains.
// Takes one item per clock while the pipeline is not stalled and returns one result per
// item, in order. The pipeline consists of the four operand and product stages, the 34
// square root cells, the 17 divider cells and the output register. Inputs are signed
// Q8.8, results signed Q24.16. A stall on the result side while a result is valid
// freezes the whole pipeline.
module vector3_fixed_point_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [15:0] in_ax,
  input  logic signed [15:0] in_ay,
  input  logic signed [15:0] in_az,
  input  logic signed [15:0] in_bx,
  input  logic signed [15:0] in_by_comp,
  input  logic signed [15:0] in_bz,
  input  logic signed [15:0] in_cx,
  input  logic signed [15:0] in_cy,
  input  logic signed [15:0] in_cz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_rx,
  output logic signed [39:0] out_ry,
  output logic signed [39:0] out_rz,
  output logic signed [39:0] out_scalar_out,
  output logic               out_status
);

  localparam int NS = vfa_pkg::N_STAGES;
  localparam int SQ0 = vfa_pkg::PRE_STAGES;
  localparam int DV0 = vfa_pkg::PRE_STAGES + vfa_pkg::SQ_CELLS;

  logic adv;
  logic v_r [NS];
  vfa_pkg::side_t side_r [NS];
  vfa_pkg::side_t side_nxt [NS];

  logic signed [16:0] op1_r [3];
  logic signed [16:0] op2_r [3];
  logic signed [33:0] pm_r [6];
  logic signed [33:0] pd_r [3];
  logic signed [31:0] pa_r [3];
  logic signed [34:0] w_r [3];
  logic [31:0]        ss_r;
  logic [31:0]        ss2_r;
  logic [67:0]        wq_r [3];

  logic signed [15:0] a_in [3];
  logic signed [15:0] b_in [3];
  logic signed [15:0] c_in [3];
  logic signed [16:0] op1_nxt [3];
  logic signed [16:0] op2_nxt [3];
  logic signed [16:0] as_nxt [3];
  logic signed [34:0] w_nxt [3];
  logic signed [35:0] dot_nxt;
  logic [33:0]        wmag [3];

  vfa_pkg::sq_t sq_i [vfa_pkg::SQ_CELLS];
  vfa_pkg::sq_t sq_o [vfa_pkg::SQ_CELLS];
  vfa_pkg::dv_t dv_i [vfa_pkg::DIV_CELLS];
  vfa_pkg::dv_t dv_o [vfa_pkg::DIV_CELLS];

  logic [2:0][15:0] amag;
  logic signed [39:0] rx_nxt, ry_nxt, rz_nxt, sc_nxt;
  logic               st_nxt;
  logic signed [39:0] qs [3];
  vfa_pkg::side_t     sd_l;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign a_in[0] = in_ax;
  assign a_in[1] = in_ay;
  assign a_in[2] = in_az;
  assign b_in[0] = in_bx;
  assign b_in[1] = in_by_comp;
  assign b_in[2] = in_bz;
  assign c_in[0] = in_cx;
  assign c_in[1] = in_cy;
  assign c_in[2] = in_cz;

  // Operands of the product stage: edges of the triangle for area, else a and b; also a+b or a-b.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_cmd == vfa_pkg::CMD_AREA) begin
        op1_nxt[i] = 17'(b_in[i]) - 17'(a_in[i]);
        op2_nxt[i] = 17'(c_in[i]) - 17'(a_in[i]);
      end else begin
        op1_nxt[i] = 17'(a_in[i]);
        op2_nxt[i] = 17'(b_in[i]);
      end
      if (in_cmd == vfa_pkg::CMD_SUB) begin
        as_nxt[i] = 17'(a_in[i]) - 17'(b_in[i]);
      end else begin
        as_nxt[i] = 17'(a_in[i]) + 17'(b_in[i]);
      end
    end
  end

  always_comb begin
    w_nxt[0] = 35'(pm_r[0]) - 35'(pm_r[1]);
    w_nxt[1] = 35'(pm_r[2]) - 35'(pm_r[3]);
    w_nxt[2] = 35'(pm_r[4]) - 35'(pm_r[5]);
    dot_nxt  = 36'(pd_r[0]) + 36'(pd_r[1]) + 36'(pd_r[2]);
    for (int i = 0; i < 3; i++) begin
      wmag[i] = w_r[i][34] ? 34'(-w_r[i]) : w_r[i][33:0];
      amag[i] = side_r[DV0-1].a[i][15] ? 16'(-side_r[DV0-1].a[i]) : side_r[DV0-1].a[i];
    end
  end

  // Side data: loaded at the entry, filled in where the chains produce results.
  always_comb begin
    side_nxt[0].cmd  = in_cmd;
    side_nxt[0].sc   = '0;
    side_nxt[0].root = '0;
    for (int i = 0; i < 3; i++) begin
      side_nxt[0].a[i]  = a_in[i];
      side_nxt[0].rv[i] = {{15{as_nxt[i][16]}}, as_nxt[i], 8'b0};
    end
    for (int k = 1; k < NS; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    if (side_r[1].cmd == vfa_pkg::CMD_CROSS) begin
      for (int i = 0; i < 3; i++) begin
        side_nxt[2].rv[i] = 40'(w_nxt[i]);
      end
    end
    side_nxt[2].sc = 40'(dot_nxt);
    side_nxt[DV0].root = sq_o[vfa_pkg::SQ_CELLS-1].root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        v_r[k] <= v_r[k-1];
      end
      out_valid <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        side_r[k] <= side_nxt[k];
      end
      for (int i = 0; i < 3; i++) begin
        op1_r[i] <= op1_nxt[i];
        op2_r[i] <= op2_nxt[i];
        pd_r[i]  <= op1_r[i] * op2_r[i];
        pa_r[i]  <= $signed(side_r[0].a[i]) * $signed(side_r[0].a[i]);
        w_r[i]   <= w_nxt[i];
        wq_r[i]  <= wmag[i] * wmag[i];
      end
      pm_r[0] <= op1_r[1] * op2_r[2];
      pm_r[1] <= op1_r[2] * op2_r[1];
      pm_r[2] <= op1_r[2] * op2_r[0];
      pm_r[3] <= op1_r[0] * op2_r[2];
      pm_r[4] <= op1_r[0] * op2_r[1];
      pm_r[5] <= op1_r[1] * op2_r[0];
      ss_r  <= 32'(pa_r[0]) + 32'(pa_r[1]) + 32'(pa_r[2]);
      ss2_r <= ss_r;
      out_rx         <= rx_nxt;
      out_ry         <= ry_nxt;
      out_rz         <= rz_nxt;
      out_scalar_out <= sc_nxt;
      out_status     <= st_nxt;
    end
  end

  // Square root chain: radicand is |w|^2 for area, else |a|^2 scaled to Q16.16.
  always_comb begin
    if (side_r[SQ0-1].cmd == vfa_pkg::CMD_AREA) begin
      sq_i[0].rad = wq_r[0] + wq_r[1] + wq_r[2];
    end else begin
      sq_i[0].rad = {20'b0, ss2_r, 16'b0};
    end
    sq_i[0].rem  = '0;
    sq_i[0].root = '0;
    for (int k = 1; k < vfa_pkg::SQ_CELLS; k++) begin
      sq_i[k] = sq_o[k-1];
    end
  end

  for (genvar k = 0; k < vfa_pkg::SQ_CELLS; k++) begin : g_sq
    vfa_sqrt_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq_i[k]),
      .d_out (sq_o[k])
    );
  end

  // Divider chain: |a_i| << 24 divided by the length, quotient bit 16 first.
  always_comb begin
    dv_i[0].dv = {sq_o[vfa_pkg::SQ_CELLS-1].root[23:0], 16'b0};
    for (int i = 0; i < 3; i++) begin
      dv_i[0].rem[i] = {amag[i], 24'b0};
      dv_i[0].q[i]   = '0;
    end
    for (int k = 1; k < vfa_pkg::DIV_CELLS; k++) begin
      dv_i[k] = dv_o[k-1];
    end
  end

  for (genvar k = 0; k < vfa_pkg::DIV_CELLS; k++) begin : g_dv
    vfa_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (dv_i[k]),
      .d_out (dv_o[k])
    );
  end

  // Result selection.
  always_comb begin
    sd_l   = side_r[NS-1];
    rx_nxt = '0;
    ry_nxt = '0;
    rz_nxt = '0;
    sc_nxt = '0;
    st_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qs[i] = sd_l.a[i][15] ? -40'(dv_o[vfa_pkg::DIV_CELLS-1].q[i])
                            : 40'(dv_o[vfa_pkg::DIV_CELLS-1].q[i]);
    end
    case (sd_l.cmd)
      vfa_pkg::CMD_ADD, vfa_pkg::CMD_SUB, vfa_pkg::CMD_CROSS: begin
        rx_nxt = sd_l.rv[0];
        ry_nxt = sd_l.rv[1];
        rz_nxt = sd_l.rv[2];
      end
      vfa_pkg::CMD_DOT: begin
        sc_nxt = sd_l.sc;
      end
      vfa_pkg::CMD_LEN: begin
        sc_nxt = 40'(sd_l.root);
      end
      vfa_pkg::CMD_NORM: begin
        sc_nxt = 40'(sd_l.root);
        if (sd_l.root == '0) begin
          st_nxt = 1'b1;
        end else begin
          rx_nxt = qs[0];
          ry_nxt = qs[1];
          rz_nxt = qs[2];
        end
      end
      vfa_pkg::CMD_AREA: begin
        sc_nxt = 40'(sd_l.root[33:1]);
      end
      default: begin
        sc_nxt = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DV0-1] |-> (37'(sq_o[vfa_pkg::SQ_CELLS-1].rem) <=
                    37'({sq_o[vfa_pkg::SQ_CELLS-1].root, 1'b0})))
    else $error("square root remainder exceeds twice the root");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && side_r[NS-1].cmd == vfa_pkg::CMD_NORM && side_r[NS-1].root != '0)
      |-> (dv_o[vfa_pkg::DIV_CELLS-1].rem[0] < 40'(side_r[NS-1].root) &&
           dv_o[vfa_pkg::DIV_CELLS-1].rem[1] < 40'(side_r[NS-1].root) &&
           dv_o[vfa_pkg::DIV_CELLS-1].rem[2] < 40'(side_r[NS-1].root)))
    else $error("divider remainder not below the divisor");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_rx == '0 && out_ry == '0 && out_rz == '0 &&
                                   out_scalar_out == '0))
    else $error("zero-length status with nonzero result");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(v_r[NS-1])))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule
